FILE: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Types and constants shared by the markup tag scanner.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int EVENT_BITS = 22;

    typedef enum logic [5:0] {
        S_TEXT, S_LT, S_LT_RAW, S_ELEM, S_ENDNAME, S_AFTER_ENDNAME, S_SLASHED,
        S_ATTRS, S_ATTR_NAME, S_EQ, S_ATTR_OR_EQ, S_BARE_VAL, S_SQ_OPEN,
        S_DQ_OPEN, S_SQ_BODY, S_DQ_BODY, S_VAL_DONE, S_BANG, S_BANG_OTHER,
        S_S_NAME, S_RAW_NAME, S_PROC, S_PROC_Q,
        S_DT1, S_DT2, S_DT3, S_DT4, S_DT5, S_DT6, S_DT7, S_DT8, S_DT9, S_DT10,
        S_CD1, S_CD2, S_CD3, S_CD4, S_CD5, S_CD6, S_CD7, S_CD8, S_CD9,
        S_DASH1, S_COMMENT, S_DASH2, S_ENDTAG_START
    } t_scan_state;

    typedef enum logic [0:0] {
        REG_XML_MODE  = 1'b0,
        REG_HTML_MODE = 1'b1
    } t_reg_index;

    localparam int EV_START_SCRIPT  = 0;
    localparam int EV_END_SCRIPT    = 1;
    localparam int EV_START_MARKUP  = 2;
    localparam int EV_END_MARKUP    = 3;
    localparam int EV_START_COMMENT = 4;
    localparam int EV_END_COMMENT   = 5;
    localparam int EV_START_DOCTYPE = 6;
    localparam int EV_END_DOCTYPE   = 7;
    localparam int EV_START_CDATA   = 8;
    localparam int EV_END_CDATA     = 9;
    localparam int EV_START_ELNAME  = 10;
    localparam int EV_END_ELNAME    = 11;
    localparam int EV_START_ATTNAME = 13;
    localparam int EV_END_ATTNAME   = 14;
    localparam int EV_START_VALUE   = 15;
    localparam int EV_END_VALUE     = 16;
    localparam int EV_END_TAG       = 19;
    localparam int EV_EMPTY_TAG     = 20;
    localparam int EV_NO_MORE_ATTS  = 21;

    localparam logic [1:0] CLS_OUT     = 2'd0;
    localparam logic [1:0] CLS_IN      = 2'd1;
    localparam logic [1:0] CLS_END     = 2'd2;
    localparam logic [1:0] CLS_END_NEW = 2'd3;

    // Character classes derived from one code point.
    typedef struct packed {
        logic       is_ascii;   // code below 0x100, low byte is the mark
        logic [7:0] low;
        logic       alpha;
        logic       alnum;
        logic       ws;
        logic       dt_ws;
        logic       punct;
    } t_char_info;

    // Expected letters of "DOCTYPE" after its "D" and of "CDATA[" after its "[".
    function automatic logic [7:0] dt_expect(input logic [2:0] i);
        case (i)
            3'd0: dt_expect = "O";
            3'd1: dt_expect = "C";
            3'd2: dt_expect = "T";
            3'd3: dt_expect = "Y";
            3'd4: dt_expect = "P";
            3'd5: dt_expect = "E";
            default: dt_expect = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] cd_expect(input logic [2:0] i);
        case (i)
            3'd0: cd_expect = "C";
            3'd1: cd_expect = "D";
            3'd2: cd_expect = "A";
            3'd3: cd_expect = "T";
            3'd4: cd_expect = "A";
            3'd5: cd_expect = "[";
            default: cd_expect = 8'd0;
        endcase
    endfunction

    // Rest of "script" (target 0) or "style" (target 1), lower case.
    function automatic logic [7:0] rest_lo(input logic t, input logic [2:0] i);
        logic [7:0] r;
        r = 8'd0;
        if (!t) begin
            case (i)
                3'd0: r = "r";
                3'd1: r = "i";
                3'd2: r = "p";
                3'd3: r = "t";
                default: r = 8'd0;
            endcase
        end else begin
            case (i)
                3'd0: r = "y";
                3'd1: r = "l";
                3'd2: r = "e";
                default: r = 8'd0;
            endcase
        end
        rest_lo = r;
    endfunction

endpackage

FILE: hw/rtl/mts_if.sv
// ----------------------------------------------------------------------------
// mts_in_if / mts_out_if / mts_cfg_if
// Valid/ready channels of the markup tag scanner.
// ----------------------------------------------------------------------------
interface mts_in_if #(parameter int CODE_BITS = 21);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  char_class;
    logic [21:0] event_mask;
    logic        raw_text_active;
    modport source (output valid, output char_class, output event_mask,
                    output raw_text_active, input ready);
    modport sink   (input valid, input char_class, input event_mask,
                    input raw_text_active, output ready);
endinterface

interface mts_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [0:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mts_next.sv
// ----------------------------------------------------------------------------
// mts_next
// Next-state, class and event logic for one character.
// ----------------------------------------------------------------------------
module mts_next #(
    parameter int CODE_BITS = 21
) (
    input  mts_pkg::t_scan_state             i_state,
    input  logic                             i_raw,
    input  logic [2:0]                       i_idx,
    input  logic                             i_tgt,
    input  logic                             i_xml,
    input  logic                             i_html,
    input  logic [CODE_BITS-1:0]             i_code,
    output mts_pkg::t_scan_state             o_state,
    output logic                             o_raw,
    output logic [2:0]                       o_idx,
    output logic                             o_tgt,
    output logic [1:0]                       o_cls,
    output logic [mts_pkg::EVENT_BITS-1:0]   o_ev
);
    import mts_pkg::*;

    t_char_info ci;
    logic [7:0] lo;

    always_comb begin
        lo = i_code[7:0];
        if (CODE_BITS > 8) ci.is_ascii = (i_code >> 8) == '0;
        else ci.is_ascii = 1'b1;
        ci.low   = lo;
        // letter ranges only below 0x100; bit 7 of the code counts as a letter
        ci.alpha = (ci.is_ascii && ((lo >= "A" && lo <= "Z") || (lo >= "a" && lo <= "z")))
                   || lo[7];
        ci.alnum = ci.alpha || (ci.is_ascii && lo >= "0" && lo <= "9");
        ci.ws    = ci.is_ascii && (lo == 8'hA0 || lo == " " || lo == 8'h09
                   || lo == 8'h0A || lo == 8'h0D);
        ci.dt_ws = ci.is_ascii && (lo == " " || lo == 8'h09 || lo == 8'h0A
                   || lo == 8'h0D);
        ci.punct = ci.is_ascii && (lo == "-" || lo == "_" || lo == ":" || lo == ".");
    end

    function automatic logic is_c(input t_char_info c, input logic [7:0] m);
        is_c = c.is_ascii && c.low == m;
    endfunction

    logic [EVENT_BITS-1:0] ev;
    logic [EVENT_BITS-1:0] e_el;
    t_scan_state st, st_el;
    logic [1:0]  cls, cls_el;
    logic        raw, raw_el;
    logic [2:0]  idx, idx_el;
    logic        tgt;
    logic [7:0]  want;
    logic [7:0]  rl;
    logic [2:0]  last;
    logic        q_open;
    logic [7:0]  q;

    // Element-name character handling; uses raw/idx as given on entry.
    task automatic elem_char(input logic r_in, input logic [2:0] i_in,
                             output t_scan_state s_o, output logic [1:0] c_o,
                             output logic [EVENT_BITS-1:0] e_o,
                             output logic r_o, output logic [2:0] i_o);
        logic part;
        part = (i_in != 3'd0) && r_in;
        s_o = S_ELEM; c_o = CLS_IN; e_o = '0; r_o = r_in; i_o = i_in;
        if (is_c(ci, "<")) begin
            s_o = S_LT; c_o = CLS_END_NEW;
            e_o[EV_END_ELNAME] = 1'b1; e_o[EV_NO_MORE_ATTS] = 1'b1;
            e_o[EV_START_MARKUP] = 1'b1;
        end else if (is_c(ci, ">")) begin
            s_o = S_TEXT; c_o = CLS_END;
            e_o[EV_END_ELNAME] = 1'b1; e_o[EV_NO_MORE_ATTS] = 1'b1;
        end else if (ci.punct) begin
            if (part) begin r_o = 1'b0; i_o = 3'd0; end
        end else if (ci.ws) begin
            s_o = S_ATTRS; e_o[EV_END_ELNAME] = 1'b1;
        end else if (is_c(ci, "/")) begin
            s_o = S_SLASHED;
            e_o[EV_END_ELNAME] = 1'b1; e_o[EV_EMPTY_TAG] = 1'b1;
            e_o[EV_NO_MORE_ATTS] = 1'b1;
        end else begin
            if (part) begin r_o = 1'b0; i_o = 3'd0; end
            if (!ci.alnum) begin s_o = S_TEXT; c_o = CLS_OUT; end
        end
    endtask

    always_comb begin
        st = i_state; cls = CLS_IN; ev = '0;
        raw = i_raw; idx = i_idx; tgt = i_tgt;
        want = 8'd0; rl = 8'd0; last = 3'd0; q_open = 1'b0; q = 8'd0;
        st_el = S_ELEM; cls_el = CLS_IN; e_el = '0; raw_el = i_raw; idx_el = i_idx;
        case (i_state)
            S_DT1, S_DT2, S_DT3, S_DT4, S_DT5, S_DT6,
            S_CD1, S_CD2, S_CD3, S_CD4, S_CD5, S_CD6: begin
                if (i_state >= S_CD1) want = cd_expect(3'(i_state - S_CD1));
                else want = dt_expect(3'(i_state - S_DT1));
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW; ev[EV_START_MARKUP] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END;
                end else if (is_c(ci, want)) begin
                    st = t_scan_state'(i_state + 6'd1);
                    if (i_state == S_CD6) ev[EV_START_CDATA] = 1'b1;
                end else st = S_BANG;
            end
            S_LT: begin
                if (is_c(ci, ">")) begin st = S_TEXT; cls = CLS_OUT; end
                else if (is_c(ci, "!")) st = S_BANG;
                else if (is_c(ci, "?")) begin st = S_PROC; ev[EV_START_SCRIPT] = 1'b1; end
                else if (is_c(ci, "/")) begin st = S_ENDTAG_START; ev[EV_END_TAG] = 1'b1; end
                else if (ci.ws) st = S_LT;
                else if ((is_c(ci, "s") || is_c(ci, "S")) && i_html && !i_xml) begin
                    st = S_S_NAME; ev[EV_START_ELNAME] = 1'b1;
                end else if (ci.alpha) begin
                    st = S_ELEM; ev[EV_START_ELNAME] = 1'b1;
                end else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_LT_RAW: begin
                if (is_c(ci, "/")) begin
                    raw = 1'b0; st = S_ENDTAG_START; ev[EV_START_MARKUP] = 1'b1;
                end else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_ELEM: begin
                elem_char(i_raw, i_idx, st, cls, ev, raw, idx);
            end
            S_S_NAME: begin
                elem_char(i_raw, i_idx, st_el, cls, ev, raw, idx);
                if (is_c(ci, "c") || is_c(ci, "C") || is_c(ci, "t") || is_c(ci, "T")) begin
                    tgt = is_c(ci, "t") || is_c(ci, "T");
                    st = S_RAW_NAME;
                end else st = st_el;
            end
            S_RAW_NAME: begin
                last = i_tgt ? 3'd2 : 3'd3;
                rl = rest_lo(i_tgt, i_idx);
                if (i_idx <= last && ci.is_ascii && rl != 8'd0
                    && (ci.low == rl || ci.low == (rl - 8'h20))) begin
                    if (i_idx == last) begin raw_el = 1'b1; idx_el = 3'd0; end
                    else idx_el = i_idx + 3'd1;
                    elem_char(raw_el, idx_el, st_el, cls_el, e_el, raw, idx);
                    st = S_RAW_NAME; cls = cls_el; ev = e_el;
                end else begin
                    elem_char(i_raw, 3'd0, st_el, cls, ev, raw, idx);
                    // name letters and punctuation keep the raw-name state
                    st = (st_el == S_ELEM) ? S_RAW_NAME : st_el;
                end
            end
            S_ENDNAME: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW; ev[EV_START_MARKUP] = 1'b1;
                    ev[EV_END_ELNAME] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END;
                    ev[EV_END_ELNAME] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (ci.punct || ci.alnum) st = S_ENDNAME;
                else if (ci.ws) begin st = S_AFTER_ENDNAME; ev[EV_END_ELNAME] = 1'b1; end
                else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_AFTER_ENDNAME, S_ENDTAG_START: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW;
                    ev[EV_START_MARKUP] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (ci.ws) st = i_state;
                else if (i_state == S_ENDTAG_START && ci.alpha) begin
                    st = S_ENDNAME; ev[EV_START_ELNAME] = 1'b1;
                end else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_SLASHED: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW; ev[EV_START_MARKUP] = 1'b1;
                end else if (is_c(ci, ">")) begin st = S_TEXT; cls = CLS_END; end
                else if (!ci.ws) begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_ATTRS, S_ATTR_OR_EQ: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW;
                    ev[EV_START_MARKUP] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (ci.ws) st = i_state;
                else if (is_c(ci, "/")) begin
                    st = S_SLASHED; ev[EV_EMPTY_TAG] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (i_state == S_ATTR_OR_EQ && is_c(ci, "=")) st = S_EQ;
                else if (i_state == S_ATTR_OR_EQ && ci.punct) begin
                    st = S_TEXT; cls = CLS_OUT;
                end else if (ci.alpha) begin
                    st = S_ATTR_NAME; ev[EV_START_ATTNAME] = 1'b1;
                end else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_ATTR_NAME: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW; ev[EV_START_MARKUP] = 1'b1;
                    ev[EV_END_ATTNAME] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END;
                    ev[EV_END_ATTNAME] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (ci.punct || ci.alnum) st = S_ATTR_NAME;
                else if (ci.ws) begin st = S_ATTR_OR_EQ; ev[EV_END_ATTNAME] = 1'b1; end
                else if (is_c(ci, "/")) begin
                    st = S_SLASHED; ev[EV_END_ATTNAME] = 1'b1; ev[EV_EMPTY_TAG] = 1'b1;
                end else if (is_c(ci, "=")) begin st = S_EQ; ev[EV_END_ATTNAME] = 1'b1; end
                else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_EQ: begin
                if (ci.ws) st = S_EQ;
                else if (is_c(ci, "'")) st = S_SQ_OPEN;
                else if (is_c(ci, "\"")) st = S_DQ_OPEN;
                else if (ci.alnum) begin st = S_BARE_VAL; ev[EV_START_VALUE] = 1'b1; end
                else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_BARE_VAL: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW; ev[EV_START_MARKUP] = 1'b1;
                    ev[EV_END_VALUE] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END;
                    ev[EV_END_VALUE] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (ci.ws) begin st = S_ATTRS; ev[EV_END_VALUE] = 1'b1; end
                else if (!ci.alnum) begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_SQ_OPEN, S_DQ_OPEN, S_SQ_BODY, S_DQ_BODY: begin
                q = (i_state == S_SQ_OPEN || i_state == S_SQ_BODY) ? "'" : "\"";
                q_open = (i_state == S_SQ_OPEN || i_state == S_DQ_OPEN);
                ev[EV_START_VALUE] = q_open;
                if (is_c(ci, q)) begin st = S_VAL_DONE; ev[EV_END_VALUE] = 1'b1; end
                else if (i_state == S_SQ_OPEN) st = S_SQ_BODY;
                else if (i_state == S_DQ_OPEN) st = S_DQ_BODY;
            end
            S_VAL_DONE: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW;
                    ev[EV_START_MARKUP] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else if (ci.ws) st = S_ATTRS;
                else if (is_c(ci, "/")) begin
                    st = S_SLASHED; ev[EV_EMPTY_TAG] = 1'b1; ev[EV_NO_MORE_ATTS] = 1'b1;
                end else begin st = S_TEXT; cls = CLS_OUT; end
            end
            S_BANG, S_BANG_OTHER: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW;
                    ev[EV_START_MARKUP] = 1'b1; ev[EV_END_MARKUP] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_END_MARKUP] = 1'b1;
                end else if (i_state == S_BANG_OTHER) st = S_BANG_OTHER;
                else if (is_c(ci, "-")) st = S_DASH1;
                else if (is_c(ci, "[")) st = S_CD1;
                else if (is_c(ci, "D")) st = S_DT1;
                else st = S_BANG_OTHER;
            end
            S_PROC: begin
                if (i_xml) begin
                    if (is_c(ci, "?")) st = S_PROC_Q;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_END_SCRIPT] = 1'b1;
                end
            end
            S_PROC_Q: begin
                if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_END_SCRIPT] = 1'b1;
                end else if (!is_c(ci, "?")) st = S_PROC;
            end
            S_DT7, S_DT8, S_DT10: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_END_NEW; ev[EV_START_MARKUP] = 1'b1;
                end else if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_END_DOCTYPE] = 1'b1;
                end else if (i_state == S_DT7) begin
                    if (ci.dt_ws) begin st = S_DT8; ev[EV_START_DOCTYPE] = 1'b1; end
                    else st = S_BANG_OTHER;
                end else if (i_state == S_DT8) begin
                    if (is_c(ci, "[")) st = S_DT9;
                end else if (!ci.dt_ws) st = S_BANG;
            end
            S_DT9: if (is_c(ci, "]")) st = S_DT10;
            S_CD7: if (is_c(ci, "]")) st = S_CD8;
            S_CD8: st = is_c(ci, "]") ? S_CD9 : S_CD7;
            S_CD9: begin
                if (is_c(ci, ">")) begin
                    st = S_TEXT; cls = CLS_END; ev[EV_END_CDATA] = 1'b1;
                end else st = S_CD7;
            end
            S_DASH1: begin
                if (is_c(ci, "<")) begin
                    st = S_LT; cls = CLS_OUT; ev[EV_START_MARKUP] = 1'b1;
                end else if (is_c(ci, ">")) begin st = S_TEXT; cls = CLS_OUT; end
                else if (is_c(ci, "-")) begin st = S_COMMENT; ev[EV_START_COMMENT] = 1'b1; end
                else st = S_BANG_OTHER;
            end
            S_COMMENT: if (is_c(ci, "-")) st = S_DASH2;
            S_DASH2: begin
                if (is_c(ci, "-")) begin st = S_BANG; ev[EV_END_COMMENT] = 1'b1; end
                else st = S_COMMENT;
            end
            default: begin
                // text state and unused codes
                if (!is_c(ci, "<")) begin st = S_TEXT; cls = CLS_OUT; end
                else if (i_raw) st = S_LT_RAW;
                else begin st = S_LT; ev[EV_START_MARKUP] = 1'b1; end
            end
        endcase
        o_state = st; o_cls = cls; o_ev = ev;
        o_raw = raw; o_idx = idx; o_tgt = tgt;
    end
endmodule

FILE: hw/rtl/markup_tag_scanner_core.sv
// ----------------------------------------------------------------------------
// markup_tag_scanner_core
// Character-by-character markup tag scanner with registered result.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in        in   char_code
// out       out  char_class, event_mask, raw_text_active
// cfg       in   index (0 xml_mode, 1 html_mode), data
//
// One character per cycle unless the output stalls; the scan state and the
// result register both load at the edge a word is accepted, so the result is
// offered in the next cycle. Input is taken whenever the output register is
// empty or being drained. Reset returns to the text state with both modes off.
// ----------------------------------------------------------------------------
module markup_tag_scanner_core #(
    parameter int CODE_BITS = 21
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mts_in_if.sink   i_in,
    mts_out_if.source o_out,
    mts_cfg_if.sink  i_cfg
);
    import mts_pkg::*;

    t_scan_state           r_state, n_state;
    logic                  r_raw, n_raw;
    logic [2:0]            r_idx, n_idx;
    logic                  r_tgt, n_tgt;
    logic                  r_xml, r_html;
    logic                  r_ovalid;
    logic [1:0]            r_cls, n_cls;
    logic [EVENT_BITS-1:0] r_ev, n_ev;
    logic                  r_oraw;
    logic                  in_acc;

    assign i_in.ready  = !r_ovalid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;

    mts_next #(.CODE_BITS(CODE_BITS)) u_next (
        .i_state(r_state), .i_raw(r_raw), .i_idx(r_idx), .i_tgt(r_tgt),
        .i_xml(r_xml), .i_html(r_html), .i_code(i_in.char_code),
        .o_state(n_state), .o_raw(n_raw), .o_idx(n_idx), .o_tgt(n_tgt),
        .o_cls(n_cls), .o_ev(n_ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_TEXT;
            r_raw    <= 1'b0;
            r_idx    <= 3'd0;
            r_tgt    <= 1'b0;
            r_xml    <= 1'b0;
            r_html   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_XML_MODE:  r_xml  <= i_cfg.data[0];
                    REG_HTML_MODE: r_html <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_state  <= n_state;
                r_raw    <= n_raw;
                r_idx    <= n_idx;
                r_tgt    <= n_tgt;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cls  <= n_cls;
            r_ev   <= n_ev;
            r_oraw <= n_raw;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.char_class      = r_cls;
    assign o_out.event_mask      = r_ev;
    assign o_out.raw_text_active = r_oraw;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_ev) && $stable(r_cls))
        else $error("result changed while stalled");
    a_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_oraw == r_raw)
        else $error("raw flag out of step with state");
    a_never: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !r_ev[12] && !r_ev[17] && !r_ev[18])
        else $error("reserved event bit set");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd3)
        else $error("name match index out of range");
endmodule

FILE: tb/sv/markup_tag_scanner_core_tb.sv
// ----------------------------------------------------------------------------
// markup_tag_scanner_core_tb
// Drives character words into the tag scanner under all mode settings and
// checks every result word against its table entry or a cycle-free scanner model kept here.
// A short table covers text extremes, the "<!-<" case and CDATA with "]]]>";
// random markup fragments (tags, attributes, comments, DOCTYPE, CDATA,
// processing instructions, script/style names) and noise make up the rest.
// ----------------------------------------------------------------------------
module markup_tag_scanner_core_tb;
    import mts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 1000;
    localparam int HOLD_CYCLES = 40;

    localparam logic [21:0] M_SSCRIPT = 22'd1 << EV_START_SCRIPT;
    localparam logic [21:0] M_ESCRIPT = 22'd1 << EV_END_SCRIPT;
    localparam logic [21:0] M_SMARK   = 22'd1 << EV_START_MARKUP;
    localparam logic [21:0] M_EMARK   = 22'd1 << EV_END_MARKUP;
    localparam logic [21:0] M_SCOMM   = 22'd1 << EV_START_COMMENT;
    localparam logic [21:0] M_ECOMM   = 22'd1 << EV_END_COMMENT;
    localparam logic [21:0] M_SDT     = 22'd1 << EV_START_DOCTYPE;
    localparam logic [21:0] M_EDT     = 22'd1 << EV_END_DOCTYPE;
    localparam logic [21:0] M_SCDATA  = 22'd1 << EV_START_CDATA;
    localparam logic [21:0] M_ECDATA  = 22'd1 << EV_END_CDATA;
    localparam logic [21:0] M_SNAME   = 22'd1 << EV_START_ELNAME;
    localparam logic [21:0] M_ENAME   = 22'd1 << EV_END_ELNAME;
    localparam logic [21:0] M_SATT    = 22'd1 << EV_START_ATTNAME;
    localparam logic [21:0] M_EATT    = 22'd1 << EV_END_ATTNAME;
    localparam logic [21:0] M_SVAL    = 22'd1 << EV_START_VALUE;
    localparam logic [21:0] M_EVAL    = 22'd1 << EV_END_VALUE;
    localparam logic [21:0] M_ENDTAG  = 22'd1 << EV_END_TAG;
    localparam logic [21:0] M_EMPTY   = 22'd1 << EV_EMPTY_TAG;
    localparam logic [21:0] M_NOMORE  = 22'd1 << EV_NO_MORE_ATTS;

    localparam logic [7:0] DT_WORD [6] = '{"O", "C", "T", "Y", "P", "E"};
    localparam logic [7:0] CD_WORD [6] = '{"C", "D", "A", "T", "A", "["};
    localparam logic [7:0] RAW_REST [2][4] = '{'{"r", "i", "p", "t"}, '{"y", "l", "e", 8'd0}};

    typedef struct {
        logic [1:0]  cls;
        logic [21:0] mask;
        logic        raw;
    } t_scan_result;

    typedef struct {
        logic [20:0]  code;
        bit           typed;
        t_scan_result res;
    } t_table_row;

    logic i_clk;
    logic i_rst_n;

    mts_in_if #(.CODE_BITS(21)) in_ch();
    mts_out_if                  out_ch();
    mts_cfg_if                  cfg_ch();

    markup_tag_scanner_core #(.CODE_BITS(21)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // scanner model state
    t_scan_state sc_state;
    logic        raw_mode;
    logic [2:0]  match_idx;
    logic        match_tgt;
    logic        xml_on;
    logic        html_on;
    logic [21:0] ev_acc;

    t_scan_result results_due[$];
    logic [20:0]  chars_pending[$];
    t_table_row   dir_rows[$];
    int           errors;
    int           idle_count;
    bit           quiet;
    bit           hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_ws(input logic [20:0] c);
        return c == 21'hA0 || c == " " || c == "\t" || c == "\n" || c == "\r";
    endfunction

    function automatic bit is_dt_ws(input logic [20:0] c);
        return c == " " || c == "\t" || c == "\n" || c == "\r";
    endfunction

    function automatic bit is_alpha(input logic [20:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c[7];
    endfunction

    function automatic bit is_alnum(input logic [20:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic bit is_punct(input logic [20:0] c);
        return c == "-" || c == "_" || c == ":" || c == ".";
    endfunction

    function automatic logic [1:0] go(input t_scan_state s, input logic [21:0] e,
                                      input logic [1:0] cls);
        sc_state = s;
        ev_acc |= e;
        return cls;
    endfunction

    function automatic logic [1:0] new_tag(input logic [21:0] e);
        return go(S_LT, e | M_SMARK, CLS_END_NEW);
    endfunction

    function automatic logic [1:0] tag_end(input logic [21:0] e);
        return go(S_TEXT, e, CLS_END);
    endfunction

    function automatic void drop_partial_raw();
        if (match_idx > 0 && raw_mode) begin
            raw_mode = 1'b0;
            match_idx = 3'd0;
        end
    endfunction

    function automatic logic [1:0] elem_char(input logic [20:0] c);
        if (c == "<") return new_tag(M_ENAME | M_NOMORE);
        if (c == ">") return tag_end(M_ENAME | M_NOMORE);
        if (is_punct(c)) begin
            drop_partial_raw();
            return CLS_IN;
        end
        if (is_ws(c)) return go(S_ATTRS, M_ENAME, CLS_IN);
        if (c == "/") return go(S_SLASHED, M_ENAME | M_EMPTY | M_NOMORE, CLS_IN);
        drop_partial_raw();
        if (is_alnum(c)) return CLS_IN;
        return go(S_TEXT, 0, CLS_OUT);
    endfunction

    function automatic logic [1:0] seq_char(input logic [20:0] c, input logic [7:0] want,
                                            input t_scan_state nxt, input logic [21:0] e);
        if (c == "<") return new_tag(0);
        if (c == ">") return tag_end(0);
        if (c == want) return go(nxt, e, CLS_IN);
        return go(S_BANG, 0, CLS_IN);
    endfunction

    // One character through the scanner; updates model state and ev_acc.
    function automatic logic [1:0] scan_char(input logic [20:0] c);
        t_scan_state s;
        logic [1:0]  r;
        logic [2:0]  last;
        logic [7:0]  lo;
        logic [20:0] q;
        s = sc_state;
        if (s >= S_DT1 && s <= S_DT6)
            return seq_char(c, DT_WORD[s - S_DT1], t_scan_state'(s + 1), 0);
        if (s >= S_CD1 && s <= S_CD6)
            return seq_char(c, CD_WORD[s - S_CD1], t_scan_state'(s + 1),
                            (s == S_CD6) ? M_SCDATA : 22'd0);
        case (s)
            S_LT: begin
                if (c == ">") return go(S_TEXT, 0, CLS_OUT);
                if (c == "!") return go(S_BANG, 0, CLS_IN);
                if (c == "?") return go(S_PROC, M_SSCRIPT, CLS_IN);
                if (c == "/") return go(S_ENDTAG_START, M_ENDTAG, CLS_IN);
                if (is_ws(c)) return CLS_IN;
                if ((c == "s" || c == "S") && html_on && !xml_on)
                    return go(S_S_NAME, M_SNAME, CLS_IN);
                if (is_alpha(c)) return go(S_ELEM, M_SNAME, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_LT_RAW: begin
                if (c == "/") begin
                    raw_mode = 1'b0;
                    return go(S_ENDTAG_START, M_SMARK, CLS_IN);
                end
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_ELEM: return elem_char(c);
            S_S_NAME: begin
                if (c == "c" || c == "C" || c == "t" || c == "T") begin
                    match_tgt = (c == "t" || c == "T");
                    r = elem_char(c);
                    sc_state = S_RAW_NAME;
                    return r;
                end
                sc_state = S_ELEM;
                return elem_char(c);
            end
            S_RAW_NAME: begin
                last = match_tgt ? 3'd2 : 3'd3;
                if (match_idx <= last) begin
                    lo = RAW_REST[match_tgt][match_idx[1:0]];
                    if (c == lo || c == (lo & 8'hDF)) begin
                        if (match_idx == last) begin
                            raw_mode = 1'b1;
                            match_idx = 3'd0;
                        end else begin
                            match_idx = match_idx + 3'd1;
                        end
                        r = elem_char(c);
                        sc_state = S_RAW_NAME;
                        return r;
                    end
                end
                match_idx = 3'd0;
                return elem_char(c);
            end
            S_ENDNAME: begin
                if (c == "<") return new_tag(M_ENAME | M_NOMORE);
                if (c == ">") return tag_end(M_ENAME | M_NOMORE);
                if (is_punct(c) || is_alnum(c)) return CLS_IN;
                if (is_ws(c)) return go(S_AFTER_ENDNAME, M_ENAME, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_AFTER_ENDNAME, S_ENDTAG_START: begin
                if (c == "<") return new_tag(M_NOMORE);
                if (c == ">") return tag_end(M_NOMORE);
                if (is_ws(c)) return CLS_IN;
                if (s == S_ENDTAG_START && is_alpha(c)) return go(S_ENDNAME, M_SNAME, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_SLASHED: begin
                if (c == "<") return new_tag(0);
                if (c == ">") return tag_end(0);
                if (is_ws(c)) return CLS_IN;
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_ATTRS, S_ATTR_OR_EQ: begin
                if (c == "<") return new_tag(M_NOMORE);
                if (c == ">") return tag_end(M_NOMORE);
                if (is_ws(c)) return CLS_IN;
                if (c == "/") return go(S_SLASHED, M_EMPTY | M_NOMORE, CLS_IN);
                if (s == S_ATTR_OR_EQ && c == "=") return go(S_EQ, 0, CLS_IN);
                if (s == S_ATTR_OR_EQ && is_punct(c)) return go(S_TEXT, 0, CLS_OUT);
                if (is_alpha(c)) return go(S_ATTR_NAME, M_SATT, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_ATTR_NAME: begin
                if (c == "<") return new_tag(M_EATT | M_NOMORE);
                if (c == ">") return tag_end(M_EATT | M_NOMORE);
                if (is_punct(c) || is_alnum(c)) return CLS_IN;
                if (is_ws(c)) return go(S_ATTR_OR_EQ, M_EATT, CLS_IN);
                if (c == "/") return go(S_SLASHED, M_EATT | M_EMPTY, CLS_IN);
                if (c == "=") return go(S_EQ, M_EATT, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_EQ: begin
                if (is_ws(c)) return CLS_IN;
                if (c == "'") return go(S_SQ_OPEN, 0, CLS_IN);
                if (c == "\"") return go(S_DQ_OPEN, 0, CLS_IN);
                if (is_alnum(c)) return go(S_BARE_VAL, M_SVAL, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_BARE_VAL: begin
                if (c == "<") return new_tag(M_EVAL | M_NOMORE);
                if (c == ">") return tag_end(M_EVAL | M_NOMORE);
                if (is_ws(c)) return go(S_ATTRS, M_EVAL, CLS_IN);
                if (is_alnum(c)) return CLS_IN;
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_SQ_OPEN, S_DQ_OPEN, S_SQ_BODY, S_DQ_BODY: begin
                q = (s == S_SQ_OPEN || s == S_SQ_BODY) ? 21'h27 : 21'h22;
                if (s == S_SQ_OPEN || s == S_DQ_OPEN) ev_acc |= M_SVAL;
                if (c == q) return go(S_VAL_DONE, M_EVAL, CLS_IN);
                if (s == S_SQ_OPEN) sc_state = S_SQ_BODY;
                if (s == S_DQ_OPEN) sc_state = S_DQ_BODY;
                return CLS_IN;
            end
            S_VAL_DONE: begin
                if (c == "<") return new_tag(M_NOMORE);
                if (c == ">") return tag_end(M_NOMORE);
                if (is_ws(c)) return go(S_ATTRS, 0, CLS_IN);
                if (c == "/") return go(S_SLASHED, M_EMPTY | M_NOMORE, CLS_IN);
                return go(S_TEXT, 0, CLS_OUT);
            end
            S_BANG, S_BANG_OTHER: begin
                if (c == "<") return new_tag(M_EMARK);
                if (c == ">") return tag_end(M_EMARK);
                if (s == S_BANG_OTHER) return CLS_IN;
                if (c == "-") return go(S_DASH1, 0, CLS_IN);
                if (c == "[") return go(S_CD1, 0, CLS_IN);
                if (c == "D") return go(S_DT1, 0, CLS_IN);
                return go(S_BANG_OTHER, 0, CLS_IN);
            end
            S_PROC: begin
                if (xml_on) begin
                    if (c == "?") return go(S_PROC_Q, 0, CLS_IN);
                    return CLS_IN;
                end
                if (c == ">") return tag_end(M_ESCRIPT);
                return CLS_IN;
            end
            S_PROC_Q: begin
                if (c == ">") return tag_end(M_ESCRIPT);
                if (c == "?") return CLS_IN;
                return go(S_PROC, 0, CLS_IN);
            end
            S_DT7, S_DT8, S_DT10: begin
                if (c == "<") return new_tag(0);
                if (c == ">") return tag_end(M_EDT);
                if (s == S_DT7) begin
                    if (is_dt_ws(c)) return go(S_DT8, M_SDT, CLS_IN);
                    return go(S_BANG_OTHER, 0, CLS_IN);
                end
                if (s == S_DT8) begin
                    if (c == "[") return go(S_DT9, 0, CLS_IN);
                    return CLS_IN;
                end
                if (is_dt_ws(c)) return CLS_IN;
                return go(S_BANG, 0, CLS_IN);
            end
            S_DT9: begin
                if (c == "]") return go(S_DT10, 0, CLS_IN);
                return CLS_IN;
            end
            S_CD7: begin
                if (c == "]") return go(S_CD8, 0, CLS_IN);
                return CLS_IN;
            end
            S_CD8: begin
                if (c == "]") return go(S_CD9, 0, CLS_IN);
                return go(S_CD7, 0, CLS_IN);
            end
            S_CD9: begin
                if (c == ">") return tag_end(M_ECDATA);
                return go(S_CD7, 0, CLS_IN);
            end
            S_DASH1: begin
                if (c == "<") return go(S_LT, M_SMARK, CLS_OUT);
                if (c == ">") return go(S_TEXT, 0, CLS_OUT);
                if (c == "-") return go(S_COMMENT, M_SCOMM, CLS_IN);
                return go(S_BANG_OTHER, 0, CLS_IN);
            end
            S_COMMENT: begin
                if (c == "-") return go(S_DASH2, 0, CLS_IN);
                return CLS_IN;
            end
            S_DASH2: begin
                if (c == "-") return go(S_BANG, M_ECOMM, CLS_IN);
                return go(S_COMMENT, 0, CLS_IN);
            end
            default: begin
                if (c != "<") return go(S_TEXT, 0, CLS_OUT);
                if (raw_mode) return go(S_LT_RAW, 0, CLS_IN);
                return go(S_LT, M_SMARK, CLS_IN);
            end
        endcase
    endfunction

    function automatic t_scan_result predict_char(input logic [20:0] c);
        t_scan_result r;
        ev_acc = 22'd0;
        r.cls  = scan_char(c);
        r.mask = ev_acc;
        r.raw  = raw_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected word", out_ch.char_class, 0);
            end else begin
                want = results_due.pop_front();
                if (out_ch.char_class !== want.cls)
                    report_mismatch("char_class", out_ch.char_class, want.cls);
                if (out_ch.event_mask !== want.mask)
                    report_mismatch("event_mask", out_ch.event_mask, want.mask);
                if (out_ch.raw_text_active !== want.raw)
                    report_mismatch("raw_text_active", out_ch.raw_text_active, want.raw);
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCH_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCH_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ---------------- result receiver ----------------
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // long hold-off: let the scanner fill and stall its input
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------- character sender ----------------
    task automatic send_char(input logic [20:0] c, input bit typed, input t_scan_result res);
        t_scan_result p;
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        p = predict_char(c);
        results_due.push_back(typed ? res : p);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_pending(input int hold_at);
        t_scan_result none;
        int n;
        none = '{default: '0};
        n = 0;
        while (chars_pending.size() > 0) begin
            if (n == hold_at) hold_req = 1'b1;
            send_char(chars_pending.pop_front(), 1'b0, none);
            n++;
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (results_due.size() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_modes(input logic xml, input logic html);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_XML_MODE;
        cfg_ch.data  <= xml;
        do @(posedge i_clk); while (!cfg_ch.ready);
        xml_on = xml;
        cfg_ch.index <= REG_HTML_MODE;
        cfg_ch.data  <= html;
        do @(posedge i_clk); while (!cfg_ch.ready);
        html_on = html;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- random markup ----------------
    function automatic logic [20:0] rand_char();
        string marks;
        marks = "<>!?/=-'\"[] _:.\t\n\rDsSt";
        case ($urandom_range(0, 9))
            0, 1, 2: return 21'("a") + 21'($urandom_range(0, 25)) - (($urandom_range(0, 1)) ? 21'd32 : 21'd0);
            3:       return 21'("0") + 21'($urandom_range(0, 9));
            4, 5:    return 21'(marks[$urandom_range(0, marks.len() - 1)]);
            6:       return 21'hA0;
            7:       return 21'($urandom_range(8'h80, 21'h10FFFF));
            default: return 21'($urandom_range(0, 21'h10FFFF));
        endcase
    endfunction

    function automatic void push_str(input string s, input bit mix_case);
        logic [20:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = 21'(s[i]);
            if (mix_case && is_alpha(c) && c < 21'h80 && $urandom_range(0, 1)) c ^= 21'h20;
            chars_pending.push_back(c);
        end
    endfunction

    function automatic void push_rand(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) chars_pending.push_back(rand_char());
    endfunction

    function automatic void push_name();
        string names [7];
        names = '{"script", "style", "scxript", "scriptt", "a", "Div", "stx"};
        if ($urandom_range(0, 3) == 0) begin
            push_str("n", 1'b0);
            repeat ($urandom_range(0, 3))
                chars_pending.push_back($urandom_range(0, 1) ? 21'($urandom_range(8'h80, 21'h10FFFF))
                                                            : 21'("-"));
        end else begin
            push_str(names[$urandom_range(0, 6)], 1'b1);
        end
    endfunction

    function automatic void push_fragment();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                push_str("<", 1'b0);
                push_name();
                repeat ($urandom_range(0, 2)) begin
                    push_str(" ", 1'b0);
                    push_name();
                    case ($urandom_range(0, 3))
                        0: ;
                        1: begin push_str("=", 1'b0); push_str("v1", 1'b1); end
                        2: begin push_str("='", 1'b0); push_rand(0, 3); push_str("'", 1'b0); end
                        default: begin
                            push_str("=\"", 1'b0); push_rand(0, 3); push_str("\"", 1'b0);
                        end
                    endcase
                end
                if ($urandom_range(0, 3) == 0) push_str(" /", 1'b0);
                push_str(">", 1'b0);
                push_rand(0, 4);
            end
            3: begin push_str("</", 1'b0); push_name(); push_str(" >", 1'b0); end
            4: begin push_str("<!--", 1'b0); push_rand(0, 5); push_str("-->", 1'b0); end
            5: begin
                push_str("<!DOCTYPE ", 1'b0); push_name();
                push_str(" [", 1'b0); push_rand(0, 4); push_str("] >", 1'b0);
            end
            6: begin push_str("<![CDATA[", 1'b0); push_rand(0, 5); push_str("]]>", 1'b0); end
            7: begin push_str("<?", 1'b0); push_rand(0, 4); push_str("?>", 1'b0); end
            8: push_rand(1, 6);
            default: push_rand(1, 3);
        endcase
    endfunction

    function automatic void add_row(input logic [20:0] c, input bit typed,
                                    input logic [1:0] cls, input logic [21:0] mask);
        t_table_row r;
        r.code = c;
        r.typed = typed;
        r.res = '{cls: cls, mask: mask, raw: 1'b0};
        dir_rows.push_back(r);
    endfunction

    // ---------------- main sequence ----------------
    initial begin
        string cdata;
        logic  modes [5][2];
        errors    = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        sc_state  = S_TEXT;
        raw_mode  = 1'b0;
        match_idx = 3'd0;
        match_tgt = 1'b0;
        xml_on    = 1'b0;
        html_on   = 1'b0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_code <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_XML_MODE;
        cfg_ch.data     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // text extremes and the "<!-" then "<" case
        add_row("x",       1'b1, CLS_OUT, 0);
        add_row(21'h0,     1'b1, CLS_OUT, 0);
        add_row(21'h10FFFF, 1'b1, CLS_OUT, 0);
        add_row("<",       1'b1, CLS_IN,  M_SMARK);
        add_row(">",       1'b1, CLS_OUT, 0);
        add_row("<",       1'b1, CLS_IN,  M_SMARK);
        add_row("!",       1'b1, CLS_IN,  0);
        add_row("-",       1'b1, CLS_IN,  0);
        add_row("<",       1'b1, CLS_OUT, M_SMARK);
        add_row(">",       1'b1, CLS_OUT, 0);
        // CDATA that "]]]>" does not close
        cdata = "<![CDATA[]]]>>";
        for (int i = 0; i < cdata.len(); i++) add_row(21'(cdata[i]), 1'b0, CLS_OUT, 0);
        foreach (dir_rows[i]) send_char(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].res);
        in_ch.valid <= 1'b0;
        drain();

        modes = '{'{1'b0, 1'b1}, '{1'b1, 1'b0}, '{1'b1, 1'b1}, '{1'b0, 1'b0}, '{1'b0, 1'b1}};
        for (int ph = 0; ph < 5; ph++) begin
            write_modes(modes[ph][0], modes[ph][1]);
            quiet = (ph == 4);
            while (chars_pending.size() < 128) push_fragment();
            send_pending(ph == 0 ? 30 : -1);
            drain();
        end

        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
